[rtl/tkbl_pkg.sv]
// ----------------------------------------------------------------------------
// tkbl_pkg
// Shared types and constants for the top-k best score list: entry payload
// types, action codes and the control bundle driven into every list cell.
// ----------------------------------------------------------------------------
package tkbl_pkg;

    // default number of list cells
    localparam int DEPTH_DEFAULT = 16;

    // highest limit that the 5-bit register and the 4-bit rank can express
    localparam int LIMIT_MAX = 16;

    // fixed field widths
    localparam int SCORE_W  = 16;
    localparam int TAG_W    = 32;
    localparam int COUNT_W  = 5;
    localparam int RANK_W   = 4;
    localparam int ACTION_W = 2;

    // reset value of the limit register
    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = COUNT_W'(16);

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic        [TAG_W-1:0]   t_tag;

    // action codes of an input transfer
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    // per-cycle command broadcast to all cells
    typedef struct packed {
        logic insert;   // place the new entry, shift the tail right
        logic rotate;   // move held entries one rank toward the head, head wraps
    } t_cell_ctrl;

endpackage

[rtl/tkbl_cell.sv]
// ----------------------------------------------------------------------------
// tkbl_cell
// One rank of the sorted list. Compares its entry with the incoming score,
// and on an insert keeps, takes the new entry or takes its left neighbor.
// During a dump it takes its right neighbor, the tail cell takes the head.
// ----------------------------------------------------------------------------
module tkbl_cell (
    input  logic                 i_clk,
    input  tkbl_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_in_list,
    input  logic                 i_is_tail,
    input  logic                 i_prev_ge,
    input  tkbl_pkg::t_score     i_new_score,
    input  tkbl_pkg::t_tag       i_new_tag,
    input  tkbl_pkg::t_score     i_left_score,
    input  tkbl_pkg::t_tag       i_left_tag,
    input  tkbl_pkg::t_score     i_right_score,
    input  tkbl_pkg::t_tag       i_right_tag,
    input  tkbl_pkg::t_score     i_head_score,
    input  tkbl_pkg::t_tag       i_head_tag,
    output logic                 o_ge,
    output tkbl_pkg::t_score     o_score,
    output tkbl_pkg::t_tag       o_tag
);

    tkbl_pkg::t_score r_score;
    tkbl_pkg::t_tag   r_tag;

    // held entry ranks ahead of the new one (ties keep arrival order)
    assign o_ge = i_in_list && (r_score >= i_new_score);

    // entry update
    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (!o_ge) begin
                if (i_prev_ge) begin
                    r_score <= i_new_score;
                    r_tag   <= i_new_tag;
                end else begin
                    r_score <= i_left_score;
                    r_tag   <= i_left_tag;
                end
            end
        end else if (i_ctrl.rotate && i_in_list) begin
            if (i_is_tail) begin
                r_score <= i_head_score;
                r_tag   <= i_head_tag;
            end else begin
                r_score <= i_right_score;
                r_tag   <= i_right_tag;
            end
        end
    end

    assign o_score = r_score;
    assign o_tag   = r_tag;

endmodule

[rtl/top_k_best_score_list.sv]
// ----------------------------------------------------------------------------
// top_k_best_score_list
// Sorted list of the best scored entries, built as a chain of list cells.
// ----------------------------------------------------------------------------
// The single result of an insert, clear or no-op action is valid in the cycle
// after the input transfer and sits in an output register. A new input
// transfer is taken only when that register is empty or its result leaves in
// the same cycle, so with the output always ready these actions follow one
// another in consecutive cycles. An insert is done by all cells at once: each
// compares with the new score and keeps, loads or shifts. A dump of N held
// entries gives N results, one per output transfer, and takes no input
// meanwhile: the chain rotates one rank per result so the head cell always
// carries the next entry, and after N steps the list is back in its original
// order. The first dump result passes the dump state and then the output
// register, and the input is held off until the last result has been loaded.
// An empty dump gives one result, timed like an insert.
module top_k_best_score_list #(
    parameter int DEPTH = tkbl_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [tkbl_pkg::COUNT_W-1:0]        i_cfg_wr_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tkbl_pkg::ACTION_W-1:0]       i_action,
    input  logic signed [tkbl_pkg::SCORE_W-1:0] i_score,
    input  logic [tkbl_pkg::TAG_W-1:0]          i_tag,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_accepted,
    output logic [tkbl_pkg::RANK_W-1:0]         o_position,
    output logic                                o_entry_valid,
    output logic signed [tkbl_pkg::SCORE_W-1:0] o_out_score,
    output logic [tkbl_pkg::TAG_W-1:0]          o_out_tag,
    output logic [tkbl_pkg::COUNT_W-1:0]        o_count,
    output logic                                o_last
);

    localparam int CAP   = (DEPTH < tkbl_pkg::LIMIT_MAX) ? DEPTH : tkbl_pkg::LIMIT_MAX;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH + 1);
    localparam int CW    = (IW > tkbl_pkg::COUNT_W) ? IW : tkbl_pkg::COUNT_W;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state                          r_state, n_state;
    logic [tkbl_pkg::COUNT_W-1:0]    r_max_entries;
    logic [tkbl_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [tkbl_pkg::RANK_W-1:0]     r_dump_idx, n_dump_idx;
    logic                            r_out_valid, n_out_valid;
    logic                            r_accepted, n_accepted;
    logic [tkbl_pkg::RANK_W-1:0]     r_position, n_position;
    logic                            r_entry_valid, n_entry_valid;
    tkbl_pkg::t_score                r_out_score, n_out_score;
    tkbl_pkg::t_tag                  r_out_tag, n_out_tag;
    logic [tkbl_pkg::COUNT_W-1:0]    r_res_count, n_res_count;
    logic                            r_last, n_last;

    logic                            w_load;
    logic                            w_accept;
    tkbl_pkg::t_cell_ctrl            w_ctrl;
    logic [tkbl_pkg::COUNT_W-1:0]    w_limit;
    logic [tkbl_pkg::COUNT_W-1:0]    w_newn;
    logic [PW-1:0]                   w_pos;
    logic                            w_keep;
    logic                            w_dump_last;
    logic [DEPTH-1:0]                w_ge;
    logic [DEPTH:0]                  w_ge_ext;
    logic [DEPTH-1:0]                w_in_list;
    logic [DEPTH-1:0]                w_tail;
    tkbl_pkg::t_score                w_cell_score [DEPTH];
    tkbl_pkg::t_tag                  w_cell_tag   [DEPTH];

    // output slot can take a new result this cycle
    assign w_load     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_load;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ctrl.insert = w_accept && (i_action == tkbl_pkg::ACT_INSERT);
    assign w_ctrl.rotate = (r_state == ST_DUMP) && w_load;

    // effective limit: zero acts as one, saturate at the cap
    always_comb begin
        if (r_max_entries == '0) begin
            w_limit = tkbl_pkg::COUNT_W'(1);
        end else if (r_max_entries > tkbl_pkg::COUNT_W'(CAP)) begin
            w_limit = tkbl_pkg::COUNT_W'(CAP);
        end else begin
            w_limit = r_max_entries;
        end
    end

    // list length after an insert
    assign w_newn = ((r_count + 1'b1) > w_limit) ? w_limit : (r_count + 1'b1);

    // rank of the new entry: first cell whose entry does not rank ahead
    assign w_ge_ext = {1'b0, w_ge};
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_ge_ext[i] && !w_ge_ext[i+1]) begin
                w_pos = w_pos | PW'(i + 1);
            end
        end
    end

    assign w_keep      = CW'(w_pos) < CW'(w_newn);
    assign w_dump_last = ({1'b0, r_dump_idx} == (r_count - 1'b1));

    // chain of list cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        tkbl_pkg::t_score l_score, rt_score;
        tkbl_pkg::t_tag   l_tag, rt_tag;
        logic             l_prev_ge;

        assign w_in_list[g] = CW'(g) < CW'(r_count);
        assign w_tail[g]    = CW'(g + 1) == CW'(r_count);

        if (g == 0) begin : g_head
            assign l_prev_ge = 1'b1;
            assign l_score   = i_score;
            assign l_tag     = i_tag;
        end else begin : g_body
            assign l_prev_ge = w_ge[g-1];
            assign l_score   = w_cell_score[g-1];
            assign l_tag     = w_cell_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign rt_score = w_cell_score[0];
            assign rt_tag   = w_cell_tag[0];
        end else begin : g_mid
            assign rt_score = w_cell_score[g+1];
            assign rt_tag   = w_cell_tag[g+1];
        end

        tkbl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_in_list    (w_in_list[g]),
            .i_is_tail    (w_tail[g]),
            .i_prev_ge    (l_prev_ge),
            .i_new_score  (i_score),
            .i_new_tag    (i_tag),
            .i_left_score (l_score),
            .i_left_tag   (l_tag),
            .i_right_score(rt_score),
            .i_right_tag  (rt_tag),
            .i_head_score (w_cell_score[0]),
            .i_head_tag   (w_cell_tag[0]),
            .o_ge         (w_ge[g]),
            .o_score      (w_cell_score[g]),
            .o_tag        (w_cell_tag[g])
        );
    end

    // sequencer next state and result fields
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_dump_idx    = r_dump_idx;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_accepted    = r_accepted;
        n_position    = r_position;
        n_entry_valid = r_entry_valid;
        n_out_score   = r_out_score;
        n_out_tag     = r_out_tag;
        n_res_count   = r_res_count;
        n_last        = r_last;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid   = 1'b1;
                    n_accepted    = 1'b0;
                    n_position    = '0;
                    n_entry_valid = 1'b0;
                    n_out_score   = '0;
                    n_out_tag     = '0;
                    n_last        = 1'b1;
                    n_res_count   = r_count;
                    case (tkbl_pkg::t_action'(i_action))
                        tkbl_pkg::ACT_INSERT: begin
                            n_count     = w_newn;
                            n_res_count = w_newn;
                            n_accepted  = w_keep;
                            n_position  = w_keep ? tkbl_pkg::RANK_W'(w_pos) : '0;
                        end
                        tkbl_pkg::ACT_CLEAR: begin
                            n_count     = '0;
                            n_res_count = '0;
                        end
                        tkbl_pkg::ACT_DUMP: begin
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_dump_idx  = '0;
                                n_state     = ST_DUMP;
                            end
                        end
                        default: begin
                            n_res_count = r_count;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (w_load) begin
                    n_out_valid   = 1'b1;
                    n_accepted    = 1'b0;
                    n_position    = r_dump_idx;
                    n_entry_valid = 1'b1;
                    n_out_score   = w_cell_score[0];
                    n_out_tag     = w_cell_tag[0];
                    n_res_count   = r_count;
                    n_last        = w_dump_last;
                    n_dump_idx    = r_dump_idx + 1'b1;
                    if (w_dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dump_idx  <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_dump_idx  <= n_dump_idx;
        end
        r_accepted    <= n_accepted;
        r_position    <= n_position;
        r_entry_valid <= n_entry_valid;
        r_out_score   <= n_out_score;
        r_out_tag     <= n_out_tag;
        r_res_count   <= n_res_count;
        r_last        <= n_last;
    end

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= tkbl_pkg::MAX_ENTRIES_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_entries <= i_cfg_wr_data;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_position    = r_position;
    assign o_entry_valid = r_entry_valid;
    assign o_out_score   = r_out_score;
    assign o_out_tag     = r_out_tag;
    assign o_count       = r_res_count;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    // list never grows past the cap
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tkbl_pkg::COUNT_W'(CAP))
        else $error("list count exceeds cap");

    // no input transfer while a dump is streaming
    a_no_accept_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> !o_in_ready)
        else $error("input taken during dump");

    // a kept insert or a dump result lands inside the list
    a_rank_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_accepted || o_entry_valid)) |->
            ({1'b0, o_position} < o_count))
        else $error("result rank outside list");

    // a dump result is followed by another unless it was the last
    a_dump_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_entry_valid && !o_last) |=>
            (r_state == ST_DUMP || o_out_valid))
        else $error("dump stream ended early");
`endif

endmodule

[sim/top_k_best_score_list_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_best_score_list_test
// Self-checking bench for the top-k best score list. A directed table covers
// the empty list, ties, score extremes, clear, no-op and limit corner values;
// random phases follow, each under a new limit, with random gaps on the input
// side and random stalls on the output side. Every output transfer is compared
// field by field with a behavioral sorted-list copy or a typed row's result.
// ----------------------------------------------------------------------------
module top_k_best_score_list_test;

    localparam int LIST_DEPTH     = tkbl_pkg::DEPTH_DEFAULT;
    localparam int LIMIT_CAP      = (LIST_DEPTH < tkbl_pkg::LIMIT_MAX) ?
                                    LIST_DEPTH : tkbl_pkg::LIMIT_MAX;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PASS = 37;
    localparam int NUM_PASSES     = 12;

    // one output transfer
    typedef struct packed {
        logic                         accepted;
        logic [tkbl_pkg::RANK_W-1:0]  position;
        logic                         entry_valid;
        tkbl_pkg::t_score             score;
        tkbl_pkg::t_tag               tag;
        logic [tkbl_pkg::COUNT_W-1:0] count;
        logic                         last;
    } t_list_result;

    // one row of the directed table: a limit write or an input transfer
    typedef struct packed {
        logic                         is_cfg;
        logic [tkbl_pkg::COUNT_W-1:0] cfg_val;
        tkbl_pkg::t_action            act;
        tkbl_pkg::t_score             score;
        tkbl_pkg::t_tag               tag;
        logic                         typed;
        t_list_result                 want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [tkbl_pkg::COUNT_W-1:0]  i_cfg_wr_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [tkbl_pkg::ACTION_W-1:0] i_action = tkbl_pkg::ACT_NOP;
    tkbl_pkg::t_score              i_score = '0;
    tkbl_pkg::t_tag                i_tag = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_accepted;
    logic [tkbl_pkg::RANK_W-1:0]   o_position;
    logic                          o_entry_valid;
    tkbl_pkg::t_score              o_out_score;
    tkbl_pkg::t_tag                o_out_tag;
    logic [tkbl_pkg::COUNT_W-1:0]  o_count;
    logic                          o_last;

    // typed expectation travels with the payload of the current input
    logic                          item_typed = 1'b0;
    t_list_result                  item_typed_res = '0;

    // behavioral copy of the list
    tkbl_pkg::t_score              best_score [LIST_DEPTH];
    tkbl_pkg::t_tag                best_tag [LIST_DEPTH];
    int unsigned                   best_len = 0;
    logic [tkbl_pkg::COUNT_W-1:0]  limit_reg = tkbl_pkg::MAX_ENTRIES_RESET;

    t_list_result                  pending_results [$];
    t_stim_row                     dir_table [$];
    int                            err_count = 0;
    int                            idle_cycles = 0;
    int                            ready_hold = 0;
    bit                            no_idle = 1'b0;

    top_k_best_score_list #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_score      (i_score),
        .i_tag        (i_tag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_accepted   (o_accepted),
        .o_position   (o_position),
        .o_entry_valid(o_entry_valid),
        .o_out_score  (o_out_score),
        .o_out_tag    (o_out_tag),
        .o_count      (o_count),
        .o_last       (o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // append one result at the tail of a result queue
    function automatic void append_result(ref t_list_result q [$], input t_list_result r);
        q.insert(q.size(), r);
    endfunction

    // append one row at the end of the directed table
    function automatic void add_row(input t_stim_row r);
        dir_table.insert(dir_table.size(), r);
    endfunction

    function automatic t_list_result mk_res(input logic acc, input int pos, input logic ev,
                                            input tkbl_pkg::t_score sc,
                                            input tkbl_pkg::t_tag tg, input int cnt,
                                            input logic fin);
        t_list_result r;
        r.accepted    = acc;
        r.position    = tkbl_pkg::RANK_W'(pos);
        r.entry_valid = ev;
        r.score       = sc;
        r.tag         = tg;
        r.count       = tkbl_pkg::COUNT_W'(cnt);
        r.last        = fin;
        return r;
    endfunction

    function automatic t_stim_row row_item(input tkbl_pkg::t_action act,
                                           input tkbl_pkg::t_score sc,
                                           input tkbl_pkg::t_tag tg);
        t_stim_row r;
        r        = '0;
        r.act    = act;
        r.score  = sc;
        r.tag    = tg;
        return r;
    endfunction

    function automatic t_stim_row row_typed(input tkbl_pkg::t_action act,
                                            input tkbl_pkg::t_score sc,
                                            input tkbl_pkg::t_tag tg,
                                            input t_list_result want);
        t_stim_row r;
        r       = row_item(act, sc, tg);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row row_cfg(input logic [tkbl_pkg::COUNT_W-1:0] val);
        t_stim_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic int unsigned effective_limit();
        int unsigned lim;
        lim = 32'(limit_reg);
        if (lim < 1) lim = 1;
        if (lim > LIMIT_CAP) lim = LIMIT_CAP;
        return lim;
    endfunction

    // update the list copy and queue what the accepted transfer should produce
    task automatic apply_item(input tkbl_pkg::t_action act, input tkbl_pkg::t_score sc,
                              input tkbl_pkg::t_tag tg, input logic typed,
                              input t_list_result typed_res);
        t_list_result outs [$];
        int unsigned  n;
        int unsigned  p;
        int unsigned  newn;
        case (act)
            tkbl_pkg::ACT_INSERT: begin
                n = (best_len > LIST_DEPTH) ? LIST_DEPTH : best_len;
                p = n;
                while (p > 0 && best_score[p-1] < sc) p--;
                newn = (n + 1 > effective_limit()) ? effective_limit() : n + 1;
                if (p < newn) begin
                    for (int i = int'(newn) - 1; i > int'(p); i--) begin
                        best_score[i] = best_score[i-1];
                        best_tag[i]   = best_tag[i-1];
                    end
                    best_score[p] = sc;
                    best_tag[p]   = tg;
                    best_len      = newn;
                    append_result(outs, mk_res(1'b1, int'(p), 1'b0, '0, '0,
                                               int'(best_len), 1'b1));
                end else begin
                    best_len = newn;
                    append_result(outs, mk_res(1'b0, 0, 1'b0, '0, '0,
                                               int'(best_len), 1'b1));
                end
            end
            tkbl_pkg::ACT_CLEAR: begin
                best_len = 0;
                append_result(outs, mk_res(1'b0, 0, 1'b0, '0, '0, 0, 1'b1));
            end
            tkbl_pkg::ACT_DUMP: begin
                n = (best_len > LIMIT_CAP) ? LIMIT_CAP : best_len;
                if (n == 0) begin
                    append_result(outs, mk_res(1'b0, 0, 1'b0, '0, '0,
                                               int'(best_len), 1'b1));
                end else begin
                    for (int k = 0; k < int'(n); k++)
                        append_result(outs, mk_res(1'b0, k, 1'b1, best_score[k],
                                                   best_tag[k], int'(best_len),
                                                   (k + 1 == int'(n))));
                end
            end
            default: begin
                append_result(outs, mk_res(1'b0, 0, 1'b0, '0, '0, int'(best_len), 1'b1));
            end
        endcase
        if (typed) append_result(pending_results, typed_res);
        else foreach (outs[i]) append_result(pending_results, outs[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("%0t ns: mismatch on %s, got %h expected %h", $realtime, what, got, want);
    endtask

    // random stall per output transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_hold = 0;
        end else if (i_out_ready && o_out_valid) begin
            ready_hold = draw_wait();
            if (ready_hold != 0) i_out_ready <= 1'b0;
        end else if (!i_out_ready) begin
            if (ready_hold <= 1) i_out_ready <= 1'b1;
            ready_hold = ready_hold - 1;
        end
    end

    // track config and input transfers, check output transfers, watchdog
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            best_len    = 0;
            limit_reg   = tkbl_pkg::MAX_ENTRIES_RESET;
            idle_cycles = 0;
        end else begin
            if (i_cfg_wr_en) limit_reg = i_cfg_wr_data;
            if (i_in_valid && o_in_ready)
                apply_item(tkbl_pkg::t_action'(i_action), i_score, i_tag, item_typed,
                           item_typed_res);
            if (o_out_valid && i_out_ready) begin
                got = mk_res(o_accepted, int'(o_position), o_entry_valid, o_out_score,
                             o_out_tag, int'(o_count), o_last);
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result tag", got.tag, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
                    if (got.position !== want.position)
                        report_mismatch("position", 32'(got.position), 32'(want.position));
                    if (got.entry_valid !== want.entry_valid)
                        report_mismatch("entry_valid", 32'(got.entry_valid),
                                        32'(want.entry_valid));
                    if (got.score !== want.score)
                        report_mismatch("out_score", 32'(got.score), 32'(want.score));
                    if (got.tag !== want.tag)
                        report_mismatch("out_tag", got.tag, want.tag);
                    if (got.count !== want.count)
                        report_mismatch("count", 32'(got.count), 32'(want.count));
                    if (got.last !== want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t ns: no transfer for %0d cycles", $realtime, idle_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // one input transfer, after a random gap
    task automatic send_item(input tkbl_pkg::t_action act, input tkbl_pkg::t_score sc,
                             input tkbl_pkg::t_tag tg, input logic typed,
                             input t_list_result typed_res);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_score        <= sc;
        i_tag          <= tg;
        item_typed     <= typed;
        item_typed_res <= typed_res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // limit write once every queued result has come out
    task automatic write_limit(input logic [tkbl_pkg::COUNT_W-1:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random_item();
        int                pick;
        tkbl_pkg::t_action act;
        tkbl_pkg::t_score  sc;
        pick = $urandom_range(0, 99);
        if (pick < 77)      act = tkbl_pkg::ACT_INSERT;
        else if (pick < 92) act = tkbl_pkg::ACT_DUMP;
        else if (pick < 95) act = tkbl_pkg::ACT_CLEAR;
        else                act = tkbl_pkg::ACT_NOP;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            // narrow range so ties are common
            sc = tkbl_pkg::t_score'(int'($urandom_range(0, 6)) - 3);
        end else if (pick < 6) begin
            case ($urandom_range(0, 3))
                0:       sc = 16'sh7fff;
                1:       sc = 16'sh8000;
                2:       sc = 16'sh0000;
                default: sc = 16'shffff;
            endcase
        end else begin
            sc = tkbl_pkg::t_score'($urandom_range(0, 65535));
        end
        send_item(act, sc, tkbl_pkg::t_tag'($urandom), 1'b0, '0);
    endtask

    // stimulus
    initial begin
        logic [tkbl_pkg::COUNT_W-1:0] pass_limits [NUM_PASSES];
        pass_limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4,
                        5'd16, 5'd2, 5'd15, 5'd8, 5'd5, 5'd16};

        add_row(row_typed(tkbl_pkg::ACT_DUMP, '0, '0,
                          mk_res(1'b0, 0, 1'b0, '0, '0, 0, 1'b1)));
        add_row(row_typed(tkbl_pkg::ACT_NOP, 16'sh7fff, 32'hffffffff,
                          mk_res(1'b0, 0, 1'b0, '0, '0, 0, 1'b1)));
        add_row(row_typed(tkbl_pkg::ACT_INSERT, 16'sh0000, 32'h0,
                          mk_res(1'b1, 0, 1'b0, '0, '0, 1, 1'b1)));
        add_row(row_typed(tkbl_pkg::ACT_INSERT, 16'sh7fff, 32'hffffffff,
                          mk_res(1'b1, 0, 1'b0, '0, '0, 2, 1'b1)));
        add_row(row_typed(tkbl_pkg::ACT_INSERT, 16'sh8000, 32'ha5a5a5a5,
                          mk_res(1'b1, 2, 1'b0, '0, '0, 3, 1'b1)));
        // ties go behind the equal entries already held
        add_row(row_item(tkbl_pkg::ACT_INSERT, 16'sh0000, 32'h1));
        add_row(row_item(tkbl_pkg::ACT_INSERT, 16'shffff, 32'h2));
        add_row(row_item(tkbl_pkg::ACT_INSERT, 16'sh7fff, 32'h3));
        add_row(row_item(tkbl_pkg::ACT_DUMP, '0, '0));
        add_row(row_typed(tkbl_pkg::ACT_CLEAR, 16'shffff, 32'hffffffff,
                          mk_res(1'b0, 0, 1'b0, '0, '0, 0, 1'b1)));
        add_row(row_typed(tkbl_pkg::ACT_DUMP, '0, '0,
                          mk_res(1'b0, 0, 1'b0, '0, '0, 0, 1'b1)));
        add_row(row_typed(tkbl_pkg::ACT_INSERT, 16'sh8000, 32'h5a5a5a5a,
                          mk_res(1'b1, 0, 1'b0, '0, '0, 1, 1'b1)));
        add_row(row_item(tkbl_pkg::ACT_INSERT, 16'sh8000, 32'h0f0f0f0f));
        add_row(row_item(tkbl_pkg::ACT_NOP, 16'sh8000, 32'h0));
        add_row(row_item(tkbl_pkg::ACT_DUMP, '0, '0));
        // limit of one, below the held count
        add_row(row_cfg(5'd1));
        add_row(row_item(tkbl_pkg::ACT_INSERT, 16'sd100, 32'h100));
        add_row(row_typed(tkbl_pkg::ACT_INSERT, 16'sd50, 32'h50,
                          mk_res(1'b0, 0, 1'b0, '0, '0, 1, 1'b1)));
        add_row(row_item(tkbl_pkg::ACT_DUMP, '0, '0));
        // zero limit acts as one
        add_row(row_cfg(5'd0));
        add_row(row_item(tkbl_pkg::ACT_INSERT, 16'sd200, 32'h200));
        add_row(row_typed(tkbl_pkg::ACT_INSERT, 16'sd200, 32'h201,
                          mk_res(1'b0, 0, 1'b0, '0, '0, 1, 1'b1)));
        // oversized limit saturates
        add_row(row_cfg(5'd31));
        add_row(row_item(tkbl_pkg::ACT_INSERT, -16'sd5, 32'hdeadbeef));
        add_row(row_item(tkbl_pkg::ACT_DUMP, '0, '0));

        // synchronous reset, once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg)
                write_limit(dir_table[i].cfg_val);
            else
                send_item(dir_table[i].act, dir_table[i].score, dir_table[i].tag,
                          dir_table[i].typed, dir_table[i].want);
        end

        // random passes, each under its own limit
        for (int ps = 0; ps < NUM_PASSES; ps++) begin
            no_idle = (ps % 4 == 1);
            if (ps % 3 == 2) write_limit(tkbl_pkg::COUNT_W'($urandom_range(0, 31)));
            else             write_limit(pass_limits[ps]);
            for (int k = 0; k < ITEMS_PER_PASS; k++) send_random_item();
        end
        no_idle = 1'b0;

        // drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[top_k_best_score_list.f]
rtl/tkbl_pkg.sv
rtl/tkbl_cell.sv
rtl/top_k_best_score_list.sv
sim/top_k_best_score_list_test.sv
